/* sv/slp_pkg.sv */
// Shared types, sizes and codes for the slot pool block.
`default_nettype none

package slp_pkg;

	localparam int SLOTS   = 128;
	localparam int GROUPS  = 256;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int LINK_W  = $clog2(SLOTS + 1);
	localparam int GROUP_W = $clog2(GROUPS);
	localparam int MODE_W  = 2;

	localparam logic [LINK_W-1:0] NONE_SLOT = LINK_W'(SLOTS);

	localparam logic [MODE_W-1:0] MODE_INIT    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MOVE    = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [SLOT_W-1:0]  slot_index;
		logic [GROUP_W-1:0] group_index;
	} req_t;

	typedef struct packed {
		logic [LINK_W-1:0] slot_result;
		logic              status;
		logic [LINK_W-1:0] active_head;
	} rsp_t;

	// datapath micro-operations, one per cycle
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_INIT,
		OP_ALLOC_FAIL,
		OP_ALLOC_RD,
		OP_ALLOC_WR,
		OP_SLOT_RD,
		OP_HEAD_HIT,
		OP_HEAD_READ,
		OP_WALK_HIT,
		OP_WALK_NEXT,
		OP_G_RD,
		OP_REL_FIN,
		OP_MV_RD,
		OP_MV_WR,
		OP_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   grp;    // walk ops: 1 = group list, 0 = active list
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              slot_ok;
		logic              free_none;
		logic              head_is_s;
		logic              head_none;
		logic              d_is_s;
		logic              d_none;
		logic              steps_full;
	} dp_stat_t;

endpackage

`default_nettype wire

/* sv/slp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module slp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* sv/slp_datapath.sv */
// Datapath: link memories, list heads, walk registers and the result register.
`default_nettype none

module slp_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire slp_pkg::req_t    req,
	input  wire slp_pkg::dp_cmd_t cmd,
	output slp_pkg::dp_stat_t     stat,
	output slp_pkg::rsp_t         rsp
);
	import slp_pkg::*;

	// latched item
	logic [MODE_W-1:0]  mode_q;
	logic [SLOT_W-1:0]  s_q;
	logic [GROUP_W-1:0] g_q;
	logic [LINK_W-1:0]  res_slot_q;
	logic               res_fail_q;

	// list state
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] ah_q;

	// walk registers
	logic [LINK_W-1:0] ls_q;
	logic [SLOT_W-1:0] cur_q;
	logic [LINK_W-1:0] steps_q;

	rsp_t rsp_q;

	// group/free link memory, with valid bits giving the chained reset value
	logic               gl_wr_en, gl_rd_en;
	logic [SLOT_W-1:0]  gl_wr_addr, gl_rd_addr, gl_raddr_q;
	logic [LINK_W-1:0]  gl_wr_data, gl_raw, gl_rd;
	logic [SLOTS-1:0]   gl_vld_q;
	logic               gl_rvld_q;

	// active link memory
	logic               al_wr_en, al_rd_en;
	logic [SLOT_W-1:0]  al_wr_addr, al_rd_addr;
	logic [LINK_W-1:0]  al_wr_data, al_rd;

	// slot group memory
	logic               sg_wr_en, sg_rd_en;
	logic [SLOT_W-1:0]  sg_wr_addr, sg_rd_addr;
	logic [GROUP_W-1:0] sg_wr_data, sg_rd;

	// group head memory, with valid bits for the empty reset value
	logic               gh_wr_en, gh_rd_en;
	logic [GROUP_W-1:0] gh_wr_addr, gh_rd_addr;
	logic [LINK_W-1:0]  gh_wr_data, gh_raw, gh_rd;
	logic [GROUPS-1:0]  gh_vld_q;
	logic               gh_rvld_q;

	logic [LINK_W-1:0] head;
	logic [LINK_W-1:0] link_rd;

	slp_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_gl_ram (
		.clk(clk), .wr_en(gl_wr_en), .wr_addr(gl_wr_addr), .wr_data(gl_wr_data),
		.rd_en(gl_rd_en), .rd_addr(gl_rd_addr), .rd_data(gl_raw)
	);

	slp_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_al_ram (
		.clk(clk), .wr_en(al_wr_en), .wr_addr(al_wr_addr), .wr_data(al_wr_data),
		.rd_en(al_rd_en), .rd_addr(al_rd_addr), .rd_data(al_rd)
	);

	slp_ram #(.WIDTH(GROUP_W), .DEPTH(SLOTS)) u_sg_ram (
		.clk(clk), .wr_en(sg_wr_en), .wr_addr(sg_wr_addr), .wr_data(sg_wr_data),
		.rd_en(sg_rd_en), .rd_addr(sg_rd_addr), .rd_data(sg_rd)
	);

	slp_ram #(.WIDTH(LINK_W), .DEPTH(GROUPS)) u_gh_ram (
		.clk(clk), .wr_en(gh_wr_en), .wr_addr(gh_wr_addr), .wr_data(gh_wr_data),
		.rd_en(gh_rd_en), .rd_addr(gh_rd_addr), .rd_data(gh_raw)
	);

	// unwritten link entry reads as its successor, unwritten head as empty
	assign gl_rd = gl_rvld_q ? gl_raw : (LINK_W'(gl_raddr_q) + LINK_W'(1));
	assign gh_rd = gh_rvld_q ? gh_raw : NONE_SLOT;

	assign head    = cmd.grp ? gh_rd : ah_q;
	assign link_rd = cmd.grp ? gl_rd : al_rd;

	always_comb begin
		stat.mode       = mode_q;
		stat.slot_ok    = LINK_W'(s_q) < NONE_SLOT;
		stat.free_none  = free_head_q >= NONE_SLOT;
		stat.head_is_s  = head == LINK_W'(s_q);
		stat.head_none  = head >= NONE_SLOT;
		stat.d_is_s     = link_rd == LINK_W'(s_q);
		stat.d_none     = link_rd >= NONE_SLOT;
		stat.steps_full = steps_q == NONE_SLOT;
	end

	always_comb begin
		gl_wr_en = 1'b0; gl_wr_addr = '0; gl_wr_data = '0;
		gl_rd_en = 1'b0; gl_rd_addr = '0;
		al_wr_en = 1'b0; al_wr_addr = '0; al_wr_data = '0;
		al_rd_en = 1'b0; al_rd_addr = '0;
		sg_wr_en = 1'b0; sg_wr_addr = '0; sg_wr_data = '0;
		sg_rd_en = 1'b0; sg_rd_addr = '0;
		gh_wr_en = 1'b0; gh_wr_addr = '0; gh_wr_data = '0;
		gh_rd_en = 1'b0; gh_rd_addr = '0;
		case (cmd.op)
			OP_ALLOC_RD: begin
				gl_rd_en   = 1'b1;
				gl_rd_addr = free_head_q[SLOT_W-1:0];
				gh_rd_en   = 1'b1;
				gh_rd_addr = g_q;
			end
			OP_ALLOC_WR: begin
				gl_wr_en   = 1'b1;
				gl_wr_addr = free_head_q[SLOT_W-1:0];
				gl_wr_data = gh_rd;
				gh_wr_en   = 1'b1;
				gh_wr_addr = g_q;
				gh_wr_data = free_head_q;
				sg_wr_en   = 1'b1;
				sg_wr_addr = free_head_q[SLOT_W-1:0];
				sg_wr_data = g_q;
				al_wr_en   = 1'b1;
				al_wr_addr = free_head_q[SLOT_W-1:0];
				al_wr_data = ah_q;
			end
			OP_SLOT_RD: begin
				al_rd_en   = 1'b1;
				al_rd_addr = s_q;
				sg_rd_en   = 1'b1;
				sg_rd_addr = s_q;
			end
			OP_HEAD_HIT: begin
				// active head is a register; group head goes to memory
				gh_wr_en   = cmd.grp;
				gh_wr_addr = sg_rd;
				gh_wr_data = gl_rd;
			end
			OP_HEAD_READ: begin
				gl_rd_en   = cmd.grp;
				gl_rd_addr = head[SLOT_W-1:0];
				al_rd_en   = !cmd.grp;
				al_rd_addr = head[SLOT_W-1:0];
			end
			OP_WALK_HIT: begin
				gl_wr_en   = cmd.grp;
				gl_wr_addr = cur_q;
				gl_wr_data = ls_q;
				al_wr_en   = !cmd.grp;
				al_wr_addr = cur_q;
				al_wr_data = ls_q;
			end
			OP_WALK_NEXT: begin
				gl_rd_en   = cmd.grp;
				gl_rd_addr = link_rd[SLOT_W-1:0];
				al_rd_en   = !cmd.grp;
				al_rd_addr = link_rd[SLOT_W-1:0];
			end
			OP_G_RD: begin
				gh_rd_en   = 1'b1;
				gh_rd_addr = sg_rd;
				gl_rd_en   = 1'b1;
				gl_rd_addr = s_q;
			end
			OP_REL_FIN: begin
				gl_wr_en   = 1'b1;
				gl_wr_addr = s_q;
				gl_wr_data = free_head_q;
			end
			OP_MV_RD: begin
				sg_wr_en   = 1'b1;
				sg_wr_addr = s_q;
				sg_wr_data = g_q;
				gh_rd_en   = 1'b1;
				gh_rd_addr = g_q;
			end
			OP_MV_WR: begin
				gl_wr_en   = 1'b1;
				gl_wr_addr = s_q;
				gl_wr_data = gh_rd;
				gh_wr_en   = 1'b1;
				gh_wr_addr = g_q;
				gh_wr_data = LINK_W'(s_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			ah_q        <= NONE_SLOT;
			gl_vld_q    <= '0;
			gh_vld_q    <= '0;
			gl_rvld_q   <= 1'b0;
			gh_rvld_q   <= 1'b0;
		end else begin
			if (cmd.op == OP_INIT) begin
				gl_vld_q <= '0;
			end else if (gl_wr_en) begin
				gl_vld_q[gl_wr_addr] <= 1'b1;
			end
			if (gh_wr_en) begin
				gh_vld_q[gh_wr_addr] <= 1'b1;
			end
			if (gl_rd_en) begin
				gl_rvld_q <= gl_vld_q[gl_rd_addr];
			end
			if (gh_rd_en) begin
				gh_rvld_q <= gh_vld_q[gh_rd_addr];
			end
			case (cmd.op)
				OP_INIT: begin
					free_head_q <= '0;
					ah_q        <= NONE_SLOT;
				end
				OP_ALLOC_WR: begin
					free_head_q <= gl_rd;
					ah_q        <= free_head_q;
				end
				OP_HEAD_HIT: begin
					if (!cmd.grp) begin
						ah_q <= al_rd;
					end
				end
				OP_REL_FIN: begin
					free_head_q <= LINK_W'(s_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (gl_rd_en) begin
			gl_raddr_q <= gl_rd_addr;
		end
		case (cmd.op)
			OP_LATCH: begin
				mode_q     <= req.mode;
				s_q        <= req.slot_index;
				g_q        <= req.group_index[GROUP_W-1:0];
				res_slot_q <= NONE_SLOT;
				res_fail_q <= 1'b0;
			end
			OP_ALLOC_FAIL: begin
				res_fail_q <= 1'b1;
			end
			OP_ALLOC_WR: begin
				res_slot_q <= free_head_q;
			end
			OP_HEAD_READ: begin
				ls_q    <= link_rd;
				cur_q   <= head[SLOT_W-1:0];
				steps_q <= LINK_W'(1);
			end
			OP_WALK_NEXT: begin
				cur_q   <= link_rd[SLOT_W-1:0];
				steps_q <= steps_q + LINK_W'(1);
			end
			OP_LOAD: begin
				rsp_q.slot_result <= res_slot_q;
				rsp_q.status      <= res_fail_q;
				rsp_q.active_head <= ah_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

/* sv/slp_ctrl.sv */
// Controller: sequences each mode as datapath micro-operations.
`default_nettype none

module slp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire slp_pkg::req_t     req,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	input  wire slp_pkg::dp_stat_t stat,
	output slp_pkg::dp_cmd_t       cmd
);
	import slp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_AL_CHK,
		ST_AL_WR,
		ST_SLOT_RD,
		ST_A_HEAD,
		ST_A_WALK,
		ST_G_RD,
		ST_G_HEAD,
		ST_G_WALK,
		ST_FIN,
		ST_MV_WR,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   stall_q;
	logic   rsp_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NOP;
		cmd.grp  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.op = OP_LATCH;
					case (req.mode)
						MODE_INIT:  state_d = ST_INIT;
						MODE_ALLOC: state_d = ST_AL_CHK;
						default:    state_d = ST_SLOT_RD;
					endcase
				end
			end
			ST_INIT: begin
				cmd.op  = OP_INIT;
				state_d = ST_DONE;
			end
			ST_AL_CHK: begin
				if (stat.free_none) begin
					cmd.op  = OP_ALLOC_FAIL;
					state_d = ST_DONE;
				end else begin
					cmd.op  = OP_ALLOC_RD;
					state_d = ST_AL_WR;
				end
			end
			ST_AL_WR: begin
				cmd.op  = OP_ALLOC_WR;
				state_d = ST_DONE;
			end
			ST_SLOT_RD: begin
				if (!stat.slot_ok) begin
					state_d = ST_DONE;
				end else begin
					cmd.op  = OP_SLOT_RD;
					state_d = (stat.mode == MODE_RELEASE) ? ST_A_HEAD : ST_G_RD;
				end
			end
			ST_A_HEAD: begin
				if (stat.head_is_s) begin
					cmd.op  = OP_HEAD_HIT;
					state_d = ST_G_RD;
				end else if (stat.head_none) begin
					state_d = ST_G_RD;
				end else begin
					cmd.op  = OP_HEAD_READ;
					state_d = ST_A_WALK;
				end
			end
			ST_A_WALK: begin
				if (stat.d_is_s) begin
					cmd.op  = OP_WALK_HIT;
					state_d = ST_G_RD;
				end else if (stat.d_none || stat.steps_full) begin
					state_d = ST_G_RD;
				end else begin
					cmd.op  = OP_WALK_NEXT;
				end
			end
			ST_G_RD: begin
				cmd.op  = OP_G_RD;
				state_d = ST_G_HEAD;
			end
			ST_G_HEAD: begin
				cmd.grp = 1'b1;
				if (stat.head_is_s) begin
					cmd.op  = OP_HEAD_HIT;
					state_d = ST_FIN;
				end else if (stat.head_none) begin
					state_d = ST_FIN;
				end else begin
					cmd.op  = OP_HEAD_READ;
					state_d = ST_G_WALK;
				end
			end
			ST_G_WALK: begin
				cmd.grp = 1'b1;
				if (stat.d_is_s) begin
					cmd.op  = OP_WALK_HIT;
					state_d = ST_FIN;
				end else if (stat.d_none || stat.steps_full) begin
					state_d = ST_FIN;
				end else begin
					cmd.op  = OP_WALK_NEXT;
				end
			end
			ST_FIN: begin
				case (stat.mode)
					MODE_RELEASE: begin
						cmd.op  = OP_REL_FIN;
						state_d = ST_DONE;
					end
					MODE_MOVE: begin
						cmd.op  = OP_MV_RD;
						state_d = ST_MV_WR;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_MV_WR: begin
				cmd.op  = OP_MV_WR;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.op  = OP_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stall_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stall_q <= state_d != ST_IDLE;
			if (cmd.op == OP_LOAD) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = stall_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* sv/slot_pool_with_linked_lists_top.sv */
// Top level of the slot pool: controller and datapath.
//
//   channel | dir | handshake            | word
//   --------+-----+----------------------+------------------------------------------
//   req     | in  | req_valid/req_stall  | mode, slot_index, group_index
//   rsp     | out | rsp_valid/rsp_stall  | slot_result, status, active_head
//
// One word at a time. The list walks do one link memory read per cycle.
// Reset clears all list heads and link valid bits at once; no clearing pass.
// The result sits in an output register, so a stalled rsp blocks only
// the finish of the next word, not its accept.
`default_nettype none

module slot_pool_with_linked_lists_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire slp_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output slp_pkg::rsp_t       rsp
);
	import slp_pkg::*;

	dp_cmd_t  cmd;   // per-cycle micro-op from the controller
	dp_stat_t stat;  // compares and mode fed back from the datapath

	// Controller: mode sequencing, list walk loops, handshakes.
	slp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: four link/group memories, free and active heads, result word.
	slp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

/* sv/slp_checker.sv */
// Port-level checker for the slot pool top, with its bind.
`default_nettype none

module slp_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire slp_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire slp_pkg::rsp_t rsp
);
	import slp_pkg::*;

	// stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp word changed while stalled");

	// one word in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("req not stalled after accept");

	// failed allocate reports no slot
	a_fail_none: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.slot_result == NONE_SLOT)
		else $error("failed allocate with a slot number");

	// a fresh allocation heads the active list
	a_alloc_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.slot_result != NONE_SLOT |-> rsp.active_head == rsp.slot_result)
		else $error("allocated slot is not the active head");

	// reported slot numbers in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.slot_result <= NONE_SLOT && rsp.active_head <= NONE_SLOT)
		else $error("slot number out of range");

endmodule

bind slot_pool_with_linked_lists_top slp_checker u_slp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

/* bench/slot_pool_with_linked_lists_top_tb.sv */
// Self-checking bench for the slot pool: directed list cases, then random mixes.
`timescale 1ns / 1ps

module slot_pool_with_linked_lists_top_tb;
	import slp_pkg::*;

	// Give up after this many cycles. The slowest legal run (every word a
	// full release walk, plus the longest idle gaps) is far below this.
	localparam int CYCLE_LIMIT = 2_000_000;
	// Quiet time after the last result; covers the longest release walk.
	localparam int DRAIN_CYCLES = 2 * SLOTS + 40;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	slot_pool_with_linked_lists_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the pool. Group and free lists share nxt_in_group.
	// ------------------------------------------------------------------
	logic [LINK_W-1:0]  nxt_in_group [SLOTS];
	logic [LINK_W-1:0]  nxt_active   [SLOTS];
	logic [GROUP_W-1:0] owner_group  [SLOTS];
	logic [LINK_W-1:0]  group_first  [GROUPS];
	logic [LINK_W-1:0]  free_first;
	logic [LINK_W-1:0]  active_first;

	// Stimulus bookkeeping: in_use marks slots handed out and not yet
	// returned; ever_alloc marks slots whose active link and group have
	// been written at least once (only those may be released or moved).
	bit in_use     [SLOTS];
	bit ever_alloc [SLOTS];

	rsp_t want_rsp [$];       // expected results, oldest first
	int   bad_count = 0;
	int   sent_cnt  = 0;
	int   cycle_cnt = 0;
	int   stall_left = 0;

	function automatic void chain_free();
		int i;
		for (i = 0; i < SLOTS - 1; i++)
			nxt_in_group[i] = LINK_W'(i + 1);
		nxt_in_group[SLOTS-1] = NONE_SLOT;
		free_first   = '0;
		active_first = NONE_SLOT;
		for (i = 0; i < SLOTS; i++)
			in_use[i] = 1'b0;
	endfunction

	function automatic void pool_reset();
		int i;
		chain_free();
		for (i = 0; i < SLOTS; i++) begin
			nxt_active[i]  = '0;
			owner_group[i] = '0;
			ever_alloc[i]  = 1'b0;
		end
		for (i = 0; i < GROUPS; i++)
			group_first[i] = NONE_SLOT;
	endfunction

	function automatic logic [LINK_W-1:0] link_of(bit grp_list, int s);
		return grp_list ? nxt_in_group[s] : nxt_active[s];
	endfunction

	// Unlink s from a list; the walk gives up after SLOTS hops or on a
	// link that is not a slot, leaving the list as it was.
	function automatic void drop_from_list(inout logic [LINK_W-1:0] head,
			input bit grp_list, input int s);
		int cur;
		int k;
		cur = head;
		if (cur == s) begin
			head = link_of(grp_list, s);
			return;
		end
		for (k = 0; k < SLOTS && cur < SLOTS; k++) begin
			if (link_of(grp_list, cur) == s) begin
				if (grp_list)
					nxt_in_group[cur] = nxt_in_group[s];
				else
					nxt_active[cur] = nxt_active[s];
				return;
			end
			cur = link_of(grp_list, cur);
		end
	endfunction

	// Apply one word to the shadow pool and return the result it must give.
	function automatic rsp_t pool_apply(req_t w);
		rsp_t r;
		int   f;
		int   s;
		int   g;
		int   old;
		r.slot_result = NONE_SLOT;
		r.status      = 1'b0;
		s = w.slot_index;
		g = w.group_index % GROUPS;
		case (w.mode)
			MODE_INIT: begin
				chain_free();
			end
			MODE_ALLOC: begin
				f = free_first;
				if (f >= SLOTS) begin
					r.status = 1'b1;
				end else begin
					free_first      = nxt_in_group[f];
					owner_group[f]  = GROUP_W'(g);
					nxt_in_group[f] = group_first[g];
					group_first[g]  = LINK_W'(f);
					nxt_active[f]   = active_first;
					active_first    = LINK_W'(f);
					r.slot_result   = LINK_W'(f);
					in_use[f]       = 1'b1;
					ever_alloc[f]   = 1'b1;
				end
			end
			MODE_RELEASE: begin
				old = owner_group[s] % GROUPS;
				drop_from_list(active_first, 1'b0, s);
				drop_from_list(group_first[old], 1'b1, s);
				nxt_in_group[s] = free_first;
				free_first      = LINK_W'(s);
				in_use[s]       = 1'b0;
			end
			default: begin
				old = owner_group[s] % GROUPS;
				drop_from_list(group_first[old], 1'b1, s);
				owner_group[s]  = GROUP_W'(g);
				nxt_in_group[s] = group_first[g];
				group_first[g]  = LINK_W'(s);
			end
		endcase
		r.active_head = active_first;
		return r;
	endfunction

	// Idle length: mostly none or short, a few long; every fourth
	// stretch of `seq` runs with no idling at all.
	function automatic int idle_len(int seq);
		int r;
		if ((seq / 80) % 4 == 3)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Slot to target: an in-use one, or (busy == 0) one that was handed
	// out once but has been returned. -1 when there is none.
	function automatic int pick_slot(bit busy);
		int base;
		int k;
		int c;
		base = $urandom_range(0, SLOTS - 1);
		for (k = 0; k < SLOTS; k++) begin
			c = (base + k) % SLOTS;
			if (busy ? in_use[c] : (ever_alloc[c] && !in_use[c]))
				return c;
		end
		return -1;
	endfunction

	// Half the words hit groups 0..3 so group lists grow long enough to walk.
	function automatic logic [GROUP_W-1:0] pick_group();
		if ($urandom_range(0, 1))
			return GROUP_W'($urandom_range(0, 3));
		return GROUP_W'($urandom_range(0, GROUPS - 1));
	endfunction

	function automatic req_t mk(logic [MODE_W-1:0] mode, int s, int g);
		req_t w;
		w.mode        = mode;
		w.slot_index  = SLOT_W'(s);
		w.group_index = GROUP_W'(g);
		return w;
	endfunction

	// Present one word and hold it until accepted; the expectation is
	// logged at the accepting edge. Valid stays high into the next word
	// when there is no gap, so it is never dropped and raised in one step.
	task automatic issue_word(input req_t w);
		int gap;
		gap = idle_len(sent_cnt);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		want_rsp.push_back(pool_apply(w));
		sent_cnt++;
	endtask

	// ------------------------------------------------------------------
	// Directed cases
	// ------------------------------------------------------------------

	// Initialise, then allocate into the lowest and highest groups, with
	// a second slot in group 0 so that list holds two entries. The slot
	// field is ignored here, so it carries its extremes.
	task automatic test_basic_alloc();
		issue_word(mk(MODE_INIT, SLOTS - 1, GROUPS - 1));
		issue_word(mk(MODE_ALLOC, 0, 0));
		issue_word(mk(MODE_ALLOC, SLOTS - 1, GROUPS - 1));
		issue_word(mk(MODE_ALLOC, 0, 0));
	endtask

	// Unlink at each list position: active list is 2,1,0 and group 0
	// holds 2,0. Move the group tail away, move a head onto its own
	// group, then release the active middle, head and last entry.
	task automatic test_unlink_positions();
		issue_word(mk(MODE_MOVE, 0, GROUPS - 1));
		issue_word(mk(MODE_MOVE, 2, 0));
		issue_word(mk(MODE_RELEASE, 1, 0));
		issue_word(mk(MODE_RELEASE, 2, GROUPS - 1));
		issue_word(mk(MODE_RELEASE, 0, 0));
	endtask

	// Initialise while slots are out: group heads keep their old slots,
	// so the next allocation links onto a stale head.
	task automatic test_reinit_stale_heads();
		issue_word(mk(MODE_ALLOC, 0, 7));
		issue_word(mk(MODE_ALLOC, SLOTS - 1, 7));
		issue_word(mk(MODE_INIT, 0, 0));
		issue_word(mk(MODE_ALLOC, 0, 7));
		issue_word(mk(MODE_ALLOC, SLOTS - 1, 0));
	endtask

	// ------------------------------------------------------------------
	// Random mixes. Weights are percent; the top two percent release or
	// move a slot that was already returned (lists get corrupted just as
	// the hardware would, until the group heads are overwritten).
	// ------------------------------------------------------------------
	task automatic test_random_mix(int n, int w_init, int w_alloc, int w_rel);
		req_t w;
		int   k;
		int   r;
		int   s;
		issue_word(mk(MODE_INIT, $urandom_range(0, SLOTS - 1), pick_group()));
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			w = mk(MODE_ALLOC, $urandom_range(0, SLOTS - 1), pick_group());
			if (r < w_init) begin
				w.mode = MODE_INIT;
			end else if (r >= w_init + w_alloc) begin
				if (r >= 98)
					w.mode = $urandom_range(0, 1) ? MODE_RELEASE : MODE_MOVE;
				else
					w.mode = (r < w_init + w_alloc + w_rel) ? MODE_RELEASE : MODE_MOVE;
				s = pick_slot(r < 98);
				if (s < 0)
					w.mode = MODE_ALLOC;
				else
					w.slot_index = SLOT_W'(s);
			end
			issue_word(w);
		end
	endtask

	// Allocation-heavy: fills the pool and keeps asking once it is empty.
	task automatic test_fill_and_exhaust();
		test_random_mix(200, 0, 85, 5);
	endtask

	// Release-heavy: walks long lists while draining them.
	task automatic test_drain();
		test_random_mix(200, 0, 10, 70);
	endtask

	// Balanced churn with an occasional initialise mid-stream.
	task automatic test_churn();
		test_random_mix(500, 1, 45, 35);
	endtask

	// Mostly moves between a handful of groups.
	task automatic test_move_heavy();
		test_random_mix(250, 0, 30, 10);
	endtask

	// ------------------------------------------------------------------
	// Result side: random backpressure, then check each accepted word.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : rsp_backpressure
		int n;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else begin
			n = idle_len(cycle_cnt / 8);
			rsp_stall  <= (n != 0);
			stall_left <= (n != 0) ? n - 1 : 0;
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (want_rsp.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected word: slot=%0d status=%0d active=%0d",
						rsp.slot_result, rsp.status, rsp.active_head);
			end else begin
				want = want_rsp.pop_front();
				if (rsp !== want) begin
					bad_count++;
					if (bad_count <= 10)
						$display("word mismatch: exp slot=%0d status=%0d active=%0d, %s%0d %0d %0d",
							want.slot_result, want.status, want.active_head,
							"got slot/status/active=",
							rsp.slot_result, rsp.status, rsp.active_head);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		pool_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_alloc();
		test_unlink_positions();
		test_reinit_stale_heads();
		test_fill_and_exhaust();
		test_drain();
		test_churn();
		test_move_heavy();

		req_valid <= 1'b0;
		while (want_rsp.size() != 0) @(posedge clk);
		// anything arriving now is an extra word and fails in rsp_check
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
